@@ src/sbbh_pkg.sv @@
// Shared types, register codes and sign helpers for the segment/box boundary test.
`timescale 1ns / 1ps
`default_nettype none

package sbbh_pkg;

  // Width of the configuration register index.
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Z = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3
  } cfg_reg_t;

  // Sign of a value: nz set when nonzero, neg set when negative.
  typedef struct packed {
    logic nz;
    logic neg;
  } sgn_t;

  // Load strobes for the product and sign stages of the cross bank.
  typedef struct packed {
    logic load_prod;
    logic load_sign;
  } sbbh_ctl_t;

  // True unless both values are nonzero with the same sign.
  function automatic logic sbbh_straddle(sgn_t a, sgn_t b);
    return !(a.nz && b.nz && (a.neg == b.neg));
  endfunction

endpackage

`default_nettype wire

@@ src/sbbh_ifs.sv @@
// Valid/ready channel interfaces for segment items and hit results.
`timescale 1ns / 1ps
`default_nettype none

interface sbbh_seg_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_z;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_z;

  modport source (
    output valid, seg_start_x, seg_start_z, seg_end_x, seg_end_z,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_z, seg_end_x, seg_end_z,
    output ready
  );
endinterface

interface sbbh_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );
  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

`default_nettype wire

@@ src/sbbh_cross_bank.sv @@
// Two-stage product and sign bank for the four box corners against the segment line.
`timescale 1ns / 1ps
`default_nettype none

module sbbh_cross_bank
  import sbbh_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire sbbh_ctl_t               ctl,
  input  wire logic signed [COORD_BITS+1:0] dx,
  input  wire logic signed [COORD_BITS+1:0] dz,
  input  wire logic signed [COORD_BITS+2:0] lx,
  input  wire logic signed [COORD_BITS+2:0] rx,
  input  wire logic signed [COORD_BITS+2:0] tz,
  input  wire logic signed [COORD_BITS+2:0] bz,
  output sgn_t                         sg_lt,
  output sgn_t                         sg_rt,
  output sgn_t                         sg_rb,
  output sgn_t                         sg_lb
);

  localparam int PW = 2 * COORD_BITS + 5;
  localparam int CW = PW + 1;

  logic signed [PW-1:0] p_tz;
  logic signed [PW-1:0] p_bz;
  logic signed [PW-1:0] p_lx;
  logic signed [PW-1:0] p_rx;

  logic signed [CW-1:0] c_lt;
  logic signed [CW-1:0] c_rt;
  logic signed [CW-1:0] c_rb;
  logic signed [CW-1:0] c_lb;

  // Four distinct products cover all four corners.
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      p_tz <= dx * tz;
      p_bz <= dx * bz;
      p_lx <= dz * lx;
      p_rx <= dz * rx;
    end
  end

  assign c_lt = {p_tz[PW-1], p_tz} - {p_lx[PW-1], p_lx};
  assign c_rt = {p_tz[PW-1], p_tz} - {p_rx[PW-1], p_rx};
  assign c_rb = {p_bz[PW-1], p_bz} - {p_rx[PW-1], p_rx};
  assign c_lb = {p_bz[PW-1], p_bz} - {p_lx[PW-1], p_lx};

  always_ff @(posedge clk) begin
    if (ctl.load_sign) begin
      sg_lt <= '{nz: (c_lt != '0), neg: c_lt[CW-1]};
      sg_rt <= '{nz: (c_rt != '0), neg: c_rt[CW-1]};
      sg_rb <= '{nz: (c_rb != '0), neg: c_rb[CW-1]};
      sg_lb <= '{nz: (c_lb != '0), neg: c_lb[CW-1]};
    end
  end

endmodule

`default_nettype wire

@@ src/segment_box_boundary_hit_top.sv @@
// Top level of the segment versus axis-aligned box boundary hit test.
`timescale 1ns / 1ps
`default_nettype none

// Streams one segment item per clock when the output is not stalled and
// returns one hit item for each, in order. A hit is 1 when the segment
// touches or crosses any of the four box sides; a zero cross product
// counts as touching, so a segment collinear with a side's line reports
// a hit even off the side, and a segment wholly inside the box reports 0.
// The box comes from four configuration registers (center x, center z,
// full width, full height, indexes 0 to 3, reset 0); write them only
// while no item is in flight. Throughput is one item per cycle while the
// output is not stalled. A result is valid from the stage 4 output
// register, which holds it while the output is stalled. Stage 1 forms box
// edges, deltas and the side-line tests, stage 2 holds the four corner
// products, stage 3 the corner cross-product signs, stage 4 the output
// register.
// Each stage holds its item under back-pressure, so the input keeps
// taking items while any stage ahead has a free slot.
module segment_box_boundary_hit_top
  import sbbh_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire [COORD_BITS-1:0]         cfg_data,
  sbbh_seg_if.sink                     seg,
  sbbh_hit_if.source                   res
);

  localparam int EW = COORD_BITS + 2;   // doubled coordinates and box edges
  localparam int DW = COORD_BITS + 3;   // corner deltas

  // Configuration registers.
  logic signed [COORD_BITS-1:0] box_center_x;
  logic signed [COORD_BITS-1:0] box_center_z;
  logic        [COORD_BITS-1:0] box_width;
  logic        [COORD_BITS-1:0] box_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_center_x <= '0;
      box_center_z <= '0;
      box_width    <= '0;
      box_height   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X: box_center_x <= cfg_data;
        CFG_CENTER_Z: box_center_z <= cfg_data;
        CFG_WIDTH:    box_width    <= cfg_data;
        CFG_HEIGHT:   box_height   <= cfg_data;
        default:      ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Box edges in doubled units; the half sizes become the full sizes.
  logic signed [EW-1:0] left;
  logic signed [EW-1:0] right;
  logic signed [EW-1:0] top;
  logic signed [EW-1:0] bottom;

  assign left   = {box_center_x[COORD_BITS-1], box_center_x, 1'b0} - {2'b00, box_width};
  assign right  = {box_center_x[COORD_BITS-1], box_center_x, 1'b0} + {2'b00, box_width};
  assign top    = {box_center_z[COORD_BITS-1], box_center_z, 1'b0} + {2'b00, box_height};
  assign bottom = {box_center_z[COORD_BITS-1], box_center_z, 1'b0} - {2'b00, box_height};

  // Doubled segment endpoints.
  logic signed [EW-1:0] sx2;
  logic signed [EW-1:0] sz2;
  logic signed [EW-1:0] ex2;
  logic signed [EW-1:0] ez2;

  assign sx2 = {seg.seg_start_x[COORD_BITS-1], seg.seg_start_x, 1'b0};
  assign sz2 = {seg.seg_start_z[COORD_BITS-1], seg.seg_start_z, 1'b0};
  assign ex2 = {seg.seg_end_x[COORD_BITS-1], seg.seg_end_x, 1'b0};
  assign ez2 = {seg.seg_end_z[COORD_BITS-1], seg.seg_end_z, 1'b0};

  // Side-line tests: each side is axis aligned, so the sign of its cross
  // product is the sign of one coordinate difference, or zero when the
  // side has no length.
  sgn_t s_top, e_top, s_bot, e_bot, s_lft, e_lft, s_rgt, e_rgt;

  assign s_top = '{nz: (sz2 != top),    neg: (sz2 < top)};
  assign e_top = '{nz: (ez2 != top),    neg: (ez2 < top)};
  assign s_bot = '{nz: (sz2 != bottom), neg: (sz2 < bottom)};
  assign e_bot = '{nz: (ez2 != bottom), neg: (ez2 < bottom)};
  assign s_lft = '{nz: (sx2 != left),   neg: (sx2 < left)};
  assign e_lft = '{nz: (ex2 != left),   neg: (ex2 < left)};
  assign s_rgt = '{nz: (sx2 != right),  neg: (sx2 < right)};
  assign e_rgt = '{nz: (ex2 != right),  neg: (ex2 < right)};

  // Side order in the flag vectors: 0 top, 1 right, 2 bottom, 3 left.
  logic [3:0] side_ok_next;

  assign side_ok_next[0] = (box_width == '0)  || sbbh_straddle(s_top, e_top);
  assign side_ok_next[1] = (box_height == '0) || sbbh_straddle(s_rgt, e_rgt);
  assign side_ok_next[2] = (box_width == '0)  || sbbh_straddle(s_bot, e_bot);
  assign side_ok_next[3] = (box_height == '0) || sbbh_straddle(s_lft, e_lft);

  // Pipeline handshake: a stage loads when it is empty or its item moves on.
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;

  assign ready4 = !v4 || res.ready;
  assign ready3 = !v3 || ready4;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  assign seg.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= seg.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  // Stage 1: segment direction, corner deltas from the start point, side flags.
  logic signed [EW-1:0] dx;
  logic signed [EW-1:0] dz;
  logic signed [DW-1:0] lx;
  logic signed [DW-1:0] rx;
  logic signed [DW-1:0] tz;
  logic signed [DW-1:0] bz;
  logic [3:0]           side_ok1;

  always_ff @(posedge clk) begin
    if (ready1) begin
      dx       <= ex2 - sx2;
      dz       <= ez2 - sz2;
      lx       <= {left[EW-1], left}     - {sx2[EW-1], sx2};
      rx       <= {right[EW-1], right}   - {sx2[EW-1], sx2};
      tz       <= {top[EW-1], top}       - {sz2[EW-1], sz2};
      bz       <= {bottom[EW-1], bottom} - {sz2[EW-1], sz2};
      side_ok1 <= side_ok_next;
    end
  end

  // Stages 2 and 3: corner products, then corner signs.
  sbbh_ctl_t ctl;
  sgn_t      sg_lt, sg_rt, sg_rb, sg_lb;

  assign ctl.load_prod = ready2;
  assign ctl.load_sign = ready3;

  sbbh_cross_bank #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk   (clk),
    .ctl   (ctl),
    .dx    (dx),
    .dz    (dz),
    .lx    (lx),
    .rx    (rx),
    .tz    (tz),
    .bz    (bz),
    .sg_lt (sg_lt),
    .sg_rt (sg_rt),
    .sg_rb (sg_rb),
    .sg_lb (sg_lb)
  );

  // Carry the side flags alongside the bank.
  logic [3:0] side_ok2;
  logic [3:0] side_ok3;

  always_ff @(posedge clk) begin
    if (ready2) side_ok2 <= side_ok1;
    if (ready3) side_ok3 <= side_ok2;
  end

  // Stage 4: combine both straddle tests for each side, hold as the output.
  logic hit_next;
  logic hit;

  assign hit_next = (side_ok3[0] && sbbh_straddle(sg_lt, sg_rt)) ||
                    (side_ok3[1] && sbbh_straddle(sg_rt, sg_rb)) ||
                    (side_ok3[2] && sbbh_straddle(sg_rb, sg_lb)) ||
                    (side_ok3[3] && sbbh_straddle(sg_lb, sg_lt));

  always_ff @(posedge clk) begin
    if (ready4) hit <= hit_next;
  end

  assign res.valid = v4;
  assign res.hit   = hit;

  // Input back-pressure only when every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !ready1 |-> (v1 && v2 && v3 && v4))
    else $error("input blocked while a pipeline slot is free");

  // An accepted item lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (seg.valid && seg.ready) |=> v1)
    else $error("accepted item lost at stage 1");

  // An item leaving stage 3 reaches the output register.
  a_stage3_moves: assert property (@(posedge clk) disable iff (rst)
    (v3 && ready4) |=> v4)
    else $error("item lost between stage 3 and the output");

  // A held item in stage 2 stays put while the stage ahead is blocked.
  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    (v2 && !ready3) |=> v2)
    else $error("stalled stage 2 item dropped");

endmodule

`default_nettype wire
